// ===== rtl/core/softmax_cross_entropy_grad_macros.svh =====
// Assertion macros shared by the RTL of the softmax cross-entropy gradient block
`ifndef SOFTMAX_CROSS_ENTROPY_GRAD_MACROS_SVH
`define SOFTMAX_CROSS_ENTROPY_GRAD_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCEG_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sceg assertion failed");
// next-cycle implication
`define SCEG_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sceg assertion failed");
`else
`define SCEG_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define SCEG_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/core/sceg_pkg.sv =====
`default_nettype none
package sceg_pkg;

    localparam int LOGIT_W = 16;
    localparam int TGT_W   = 16;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 13;
    localparam int EXP_W   = 17;   // exp in Q0.16, up to 1.0
    localparam int DIVD_W  = 48;
    localparam int DIVS_W  = 32;

    typedef logic [1:0]       t_op;
    typedef logic [1:0]       t_kind;
    typedef logic [VAL_W-1:0] t_val;

    localparam t_op OP_LOAD  = 2'd0;
    localparam t_op OP_CLOSE = 2'd1;
    localparam t_op OP_GRAD  = 2'd2;
    localparam t_op OP_SEQ   = 2'd3;

    localparam t_kind KIND_ROW  = 2'd0;
    localparam t_kind KIND_GRAD = 2'd1;
    localparam t_kind KIND_MEAN = 2'd2;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] LN2_Q16   = 16'd45426;
    localparam logic [20:0] LN_BIAS   = 21'd726816;  // 16 * ln2 in Q16
    localparam logic [CFG_W-1:0] VOCAB_RST = 13'd4096;

    // Q30 factors 2^(-2^-j), each the floor square root of the one before
    typedef logic [16:0][30:0] t_pow_tab;

    function automatic t_pow_tab f_pow_tab();
        t_pow_tab    tab;
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        tab    = '0;
        tab[0] = 31'(64'd1 << 29);
        for (int j = 1; j <= 16; j++) begin
            n   = 64'(tab[j-1]) << 30;
            res = '0;
            b   = 64'd1 << 62;
            for (int s = 0; s < 32; s++) begin
                if (b > n) b = b >> 2;
            end
            for (int s = 0; s < 32; s++) begin
                if (b != 0) begin
                    if (n >= res + b) begin
                        n   = n - (res + b);
                        res = (res >> 1) + b;
                    end else begin
                        res = res >> 1;
                    end
                    b = b >> 2;
                end
            end
            tab[j] = 31'(res);
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = f_pow_tab();

endpackage
`default_nettype wire

// ===== rtl/core/sceg_if.sv =====
`default_nettype none
// input item channel
interface sceg_in_if;
    logic                                  valid;
    logic                                  ready;
    sceg_pkg::t_op                         op;
    logic signed [sceg_pkg::LOGIT_W-1:0]   logit;
    logic signed [sceg_pkg::TGT_W-1:0]     target;

    modport source (output valid, op, logit, target, input ready);
    modport sink   (input valid, op, logit, target, output ready);
endinterface

// result item channel
interface sceg_out_if;
    logic                  valid;
    logic                  ready;
    sceg_pkg::t_kind       kind;
    sceg_pkg::t_val        value;
    logic                  last_of_row;

    modport source (output valid, kind, value, last_of_row, input ready);
    modport sink   (input valid, kind, value, last_of_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/softmax_cross_entropy_grad.sv =====
`default_nettype none
// Softmax cross-entropy gradient engine. A load (op 0) writes the logit
// store without leaving idle, and a gradient read past the row end is taken
// the same way. Work is done by a shared exp unit (one Q30 multiply per
// cycle), a one-bit-per-cycle divider and a log unit: a row close walks the
// store once through the exp unit, then reads the target and runs the log; a
// gradient read runs the exp unit and then the divider; a sequence close runs
// the divider unless no row was closed. The logit store powers up undefined
// and needs no clearing pass. Each result goes into an output register, so
// the next item is taken while that beat waits on the sink.
`include "softmax_cross_entropy_grad_macros.svh"
module softmax_cross_entropy_grad #(
    parameter int VOCAB_MAX = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [sceg_pkg::CFG_W-1:0]   i_cfg_data,
    sceg_in_if.sink                           i_in,
    sceg_out_if.source                        o_out
);
    import sceg_pkg::*;

    localparam int VW = $clog2(VOCAB_MAX + 1);
    localparam int AW = $clog2(VOCAB_MAX);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_W_RD     = 4'd1;
    localparam logic [3:0] S_W_ST     = 4'd2;
    localparam logic [3:0] S_W_WAIT   = 4'd3;
    localparam logic [3:0] S_T_RD     = 4'd4;
    localparam logic [3:0] S_T_LN     = 4'd5;
    localparam logic [3:0] S_LN_WAIT  = 4'd6;
    localparam logic [3:0] S_G_ST     = 4'd7;
    localparam logic [3:0] S_G_WAIT   = 4'd8;
    localparam logic [3:0] S_DIV_WAIT = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    localparam logic signed [47:0] TOTAL_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] TOTAL_MIN = 48'sh8000_0000_0000;

    // control and state
    logic [3:0]               r_state;
    logic [CFG_W-1:0]         r_vocab;
    logic [VW-1:0]            r_load_idx;
    logic [VW-1:0]            r_read_idx;
    logic [VW-1:0]            r_idx;
    logic [VW-1:0]            r_grad_idx;
    logic signed [LOGIT_W-1:0] r_row_max;
    logic [31:0]              r_exp_sum;
    logic [AW-1:0]            r_target;
    logic signed [47:0]       r_total;
    logic [15:0]              r_count;
    logic                     r_div_grad;
    logic                     r_neg;
    logic signed [16:0]       r_diff;
    // result staging and output register
    t_kind                    r_res_kind;
    t_val                     r_res_value;
    logic                     r_res_last;
    logic                     r_out_valid;
    t_kind                    r_out_kind;
    t_val                     r_out_value;
    logic                     r_out_last;

    logic                     in_acc;
    logic                     out_free;
    logic [31:0]              cfg_w;
    logic [31:0]              v32;
    logic [VW-1:0]            v_eff;
    logic signed [31:0]       t32;
    logic [AW-1:0]            tgt_clamp;
    logic                     mem_we;
    logic [AW-1:0]            mem_raddr;
    logic [LOGIT_W-1:0]       mem_rdata;
    logic                     exp_start;
    logic                     exp_done;
    logic [EXP_W-1:0]         exp_val;
    logic                     ln_done;
    logic signed [VAL_W-1:0]  ln_val;
    logic                     div_start;
    logic [DIVD_W-1:0]        div_dvd;
    logic [DIVS_W-1:0]        div_dvs;
    logic                     div_done;
    logic [DIVD_W-1:0]        div_quo;
    logic [DIVD_W-1:0]        total_mag;
    logic [31:0]              s_eff;
    logic [32:0]              acc_sum;
    logic signed [33:0]       ce_wide;
    logic signed [31:0]       ce;
    logic signed [48:0]       total_wide;
    logic [16:0]              p_val;
    logic signed [LOGIT_W-1:0] x_in;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign x_in     = i_in.logit;

    // effective vocabulary size, clamped into 1..VOCAB_MAX
    always_comb begin
        cfg_w = 32'(r_vocab);
        if (cfg_w == 32'd0)                    v32 = 32'd1;
        else if (cfg_w > 32'(VOCAB_MAX))       v32 = 32'(VOCAB_MAX);
        else                                   v32 = cfg_w;
        v_eff = v32[VW-1:0];
    end

    // target clamp
    always_comb begin
        t32 = 32'(i_in.target);
        if (t32 < 0)                  tgt_clamp = '0;
        else if (t32 >= $signed(v32)) tgt_clamp = AW'(v32 - 32'd1);
        else                          tgt_clamp = AW'(t32);
    end

    // store address and write
    assign mem_we = in_acc && (i_in.op == OP_LOAD) && (r_load_idx < v_eff);
    always_comb begin
        unique case (r_state)
            S_W_RD:  mem_raddr = r_idx[AW-1:0];
            S_T_RD:  mem_raddr = r_target;
            default: mem_raddr = r_read_idx[AW-1:0];
        endcase
    end

    // arithmetic unit hookup
    assign exp_start = (r_state == S_W_ST) || (r_state == S_G_ST);
    assign s_eff     = (r_exp_sum == 32'd0) ? 32'd1 : r_exp_sum;
    assign total_mag = r_total[47] ? DIVD_W'(-r_total) : DIVD_W'(r_total);
    assign div_start = (in_acc && (i_in.op == OP_SEQ) && (r_count != 16'd0))
                    || ((r_state == S_G_WAIT) && exp_done);
    assign div_dvd   = (r_state == S_G_WAIT) ? DIVD_W'({exp_val, 16'd0}) : total_mag;
    assign div_dvs   = (r_state == S_G_WAIT) ? s_eff : DIVS_W'(r_count);

    // sums and saturation
    always_comb begin
        acc_sum    = 33'(r_exp_sum) + 33'(exp_val);
        ce_wide    = 34'(signed'({r_diff, 6'd0})) + 34'(ln_val);
        if (ce_wide > 34'sh0_7FFF_FFFF)       ce = 32'sh7FFF_FFFF;
        else if (ce_wide < -34'sh0_8000_0000) ce = 32'sh8000_0000;
        else                                  ce = 32'(ce_wide);
        total_wide = 49'(r_total) + 49'(ce);
        p_val      = (div_quo > 48'd65536) ? 17'd65536 : div_quo[16:0];
    end

    sceg_mem #(.DEPTH(VOCAB_MAX), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_load_idx[AW-1:0]),
        .i_wdata (i_in.logit),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sceg_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (exp_start),
        .i_logit (mem_rdata),
        .i_max   (r_row_max),
        .o_done  (exp_done),
        .o_exp   (exp_val)
    );

    sceg_ln u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_T_LN),
        .i_sum   (r_exp_sum),
        .o_done  (ln_done),
        .o_ln    (ln_val)
    );

    sceg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vocab     <= VOCAB_RST;
            r_load_idx  <= '0;
            r_read_idx  <= '0;
            r_idx       <= '0;
            r_row_max   <= {1'b1, {(LOGIT_W-1){1'b0}}};
            r_exp_sum   <= '0;
            r_target    <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_vocab <= i_cfg_data;
            // output register: load a staged result or drain the taken beat
            if ((r_state == S_EMIT) && out_free) r_out_valid <= 1'b1;
            else if (o_out.ready)                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in.op)
                            OP_LOAD: begin
                                if (r_load_idx < v_eff) begin
                                    if (r_load_idx == '0 || x_in > r_row_max)
                                        r_row_max <= x_in;
                                    r_load_idx <= r_load_idx + 1'b1;
                                end
                            end
                            OP_CLOSE: begin
                                r_target  <= tgt_clamp;
                                r_exp_sum <= '0;
                                r_idx     <= '0;
                                r_state   <= S_W_RD;
                            end
                            OP_GRAD: begin
                                if (r_read_idx < v_eff) begin
                                    r_grad_idx <= r_read_idx;
                                    r_read_idx <= r_read_idx + 1'b1;
                                    r_state    <= S_G_ST;
                                end
                            end
                            OP_SEQ: begin
                                r_total <= '0;
                                r_count <= '0;
                                r_neg   <= r_total[47];
                                if (r_count == 16'd0) begin
                                    r_res_kind  <= KIND_MEAN;
                                    r_res_value <= '0;
                                    r_res_last  <= 1'b0;
                                    r_state     <= S_EMIT;
                                end else begin
                                    r_div_grad <= 1'b0;
                                    r_state    <= S_DIV_WAIT;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                // walk the row, summing exp with saturation
                S_W_RD: r_state <= S_W_ST;
                S_W_ST: r_state <= S_W_WAIT;
                S_W_WAIT: begin
                    if (exp_done) begin
                        r_exp_sum <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                        if (r_idx == v_eff - 1'b1) begin
                            r_state <= S_T_RD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_W_RD;
                        end
                    end
                end
                S_T_RD: begin
                    if (r_exp_sum == 32'd0) r_exp_sum <= 32'd1;
                    r_state <= S_T_LN;
                end
                S_T_LN: begin
                    r_diff  <= {r_row_max[LOGIT_W-1], r_row_max}
                             - {mem_rdata[LOGIT_W-1], mem_rdata};
                    r_state <= S_LN_WAIT;
                end
                S_LN_WAIT: begin
                    if (ln_done) begin
                        if (total_wide > 49'(TOTAL_MAX))      r_total <= TOTAL_MAX;
                        else if (total_wide < 49'(TOTAL_MIN)) r_total <= TOTAL_MIN;
                        else                                  r_total <= 48'(total_wide);
                        if (r_count != 16'hFFFF) r_count <= r_count + 16'd1;
                        r_load_idx  <= '0;
                        r_read_idx  <= '0;
                        r_res_kind  <= KIND_ROW;
                        r_res_value <= ce;
                        r_res_last  <= 1'b0;
                        r_state     <= S_EMIT;
                    end
                end
                // gradient element
                S_G_ST: r_state <= S_G_WAIT;
                S_G_WAIT: begin
                    if (exp_done) begin
                        r_div_grad <= 1'b1;
                        r_state    <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (r_div_grad) begin
                            r_res_kind  <= KIND_GRAD;
                            r_res_value <= 32'(p_val)
                                - ((r_grad_idx == VW'(r_target)) ? 32'd65536 : 32'd0);
                            r_res_last  <= (r_grad_idx == v_eff - 1'b1);
                        end else begin
                            r_res_kind <= KIND_MEAN;
                            r_res_last <= 1'b0;
                            if (!r_neg)
                                r_res_value <= (div_quo > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                       : div_quo[31:0];
                            else
                                r_res_value <= (div_quo > 48'h8000_0000) ? 32'h8000_0000
                                                                       : -div_quo[31:0];
                        end
                        r_state <= S_EMIT;
                    end
                end
                // hand the result to the output register
                S_EMIT: begin
                    if (out_free) begin
                        r_out_kind  <= r_res_kind;
                        r_out_value <= r_res_value;
                        r_out_last  <= r_res_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out_kind;
    assign o_out.value       = r_out_value;
    assign o_out.last_of_row = r_out_last;

    `SCEG_ASSERT_IMP(a_load_in_row, i_clk, i_rst_n, 1'b1, r_load_idx <= v_eff)
    `SCEG_ASSERT_NXT(a_close_clears_idx, i_clk, i_rst_n, ln_done, (r_load_idx == '0) && (r_read_idx == '0))
    `SCEG_ASSERT_NXT(a_emit_loads_out, i_clk, i_rst_n, (r_state == S_EMIT) && out_free, r_out_valid && (r_state == S_IDLE))
endmodule
`default_nettype wire

// ===== rtl/core/sceg_mem.sv =====
`default_nettype none
module sceg_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [AW-1:0]                    i_waddr,
    input  wire logic [sceg_pkg::LOGIT_W-1:0]     i_wdata,
    input  wire logic [AW-1:0]                    i_raddr,
    output logic      [sceg_pkg::LOGIT_W-1:0]     o_rdata
);
    import sceg_pkg::*;

    logic [LOGIT_W-1:0] r_mem [DEPTH];
    logic [LOGIT_W-1:0] r_rdata;

    // logit store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/core/sceg_exp.sv =====
`default_nettype none
// exp(logit - max) in Q0.16, one Q30 factor per cycle
module sceg_exp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [sceg_pkg::LOGIT_W-1:0]   i_logit,
    input  wire logic signed [sceg_pkg::LOGIT_W-1:0]   i_max,
    output logic                                       o_done,
    output logic [sceg_pkg::EXP_W-1:0]                 o_exp
);
    import sceg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [22:0]       r_y;
    logic [30:0]       r_r;
    logic [EXP_W-1:0]  r_exp;

    logic signed [16:0] d;
    logic [15:0]        mag;
    logic [32:0]        y_full;
    logic [4:0]         bidx;
    logic               fbit;
    logic [61:0]        prod;
    logic [7:0]         sh;
    logic [EXP_W-1:0]   exp_val;

    // argument scaled by log2(e), positive part clamped to zero
    always_comb begin
        d      = {i_logit[LOGIT_W-1], i_logit} - {i_max[LOGIT_W-1], i_max};
        mag    = d[16] ? 16'(-d) : 16'd0;
        y_full = 33'(mag) * 33'(LOG2E_Q16);
        bidx   = 5'd16 - r_cnt;
        fbit   = r_y[bidx[3:0]];
        prod   = 62'(r_r) * 62'(POW_TAB[r_cnt]);
        sh     = 8'(r_y[22:16]) + 8'd14;
        exp_val = (sh >= 8'd63) ? '0 : EXP_W'(r_r >> sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd1;
                r_r    <= 31'h4000_0000;
                r_y    <= y_full[32:10];
            end else if (r_busy) begin
                if (r_cnt == 5'd17) begin
                    r_exp  <= exp_val;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    if (fbit) r_r <= prod[60:30];
                    r_cnt <= r_cnt + 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_exp  = r_exp;
endmodule
`default_nettype wire

// ===== rtl/core/sceg_ln.sv =====
`default_nettype none
// ln(sum / 2^16) in Q16: normalize one bit a cycle, then 16 squarings
module sceg_ln (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [31:0]                 i_sum,
    output logic                             o_done,
    output logic signed [sceg_pkg::VAL_W-1:0] o_ln
);
    import sceg_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_NORM = 2'd1;
    localparam logic [1:0] P_SQ   = 2'd2;
    localparam logic [1:0] P_FIN  = 2'd3;

    logic [1:0]        r_phase;
    logic              r_done;
    logic [31:0]       r_s;
    logic [4:0]        r_k;
    logic [30:0]       r_m;
    logic [15:0]       r_frac;
    logic [3:0]        r_cnt;
    logic [VAL_W-1:0]  r_ln;

    logic [61:0] sq_full;
    logic [31:0] sq;
    logic [36:0] l2_prod;
    logic [VAL_W-1:0] ln_val;

    always_comb begin
        sq_full = 62'(r_m) * 62'(r_m);
        sq      = sq_full[61:30];
        l2_prod = 37'({r_k, r_frac}) * 37'(LN2_Q16);
        ln_val  = VAL_W'(l2_prod[36:16]) - VAL_W'(LN_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_s     <= i_sum;
                        r_k     <= 5'd31;
                        r_phase <= P_NORM;
                    end
                end
                // leading one to bit 31, mantissa in Q30
                P_NORM: begin
                    if (r_s[31]) begin
                        r_m     <= r_s[31:1];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_phase <= P_SQ;
                    end else begin
                        r_s <= r_s << 1;
                        r_k <= r_k - 5'd1;
                    end
                end
                P_SQ: begin
                    if (sq[31]) begin
                        r_m    <= sq[31:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_m    <= sq[30:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) r_phase <= P_FIN;
                end
                P_FIN: begin
                    r_ln    <= ln_val;
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_ln   = r_ln;
endmodule
`default_nettype wire

// ===== rtl/core/sceg_div.sv =====
`default_nettype none
// unsigned restoring divider, one quotient bit per cycle
module sceg_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sceg_pkg::DIVD_W-1:0]   i_dividend,
    input  wire logic [sceg_pkg::DIVS_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [sceg_pkg::DIVD_W-1:0]        o_quo
);
    import sceg_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [DIVS_W:0]   r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0] trial;
    logic            fits;

    always_comb begin
        trial = {r_rem[DIVS_W-1:0], r_quo[DIVD_W-1]};
        fits  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? trial - {1'b0, r_dvs} : trial;
                r_quo <= {r_quo[DIVD_W-2:0], fits};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ===== test/sceg_scoreboard.sv =====
// Watches both channels and the config port, predicts every result beat and
// compares it with what the block returns.
module sceg_scoreboard (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sceg_pkg::CFG_W-1:0]   i_cfg_data,
    sceg_in_if                           i_in,
    sceg_out_if                          i_out,
    output int                           o_fail_count,
    output int                           o_pending
);
    import sceg_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } loss_beat_t;

    localparam int          NLOGIT    = 4096;
    localparam longint      TOT_MAX   = 64'sh7FFF_FFFF_FFFF;
    localparam longint      TOT_MIN   = -TOT_MAX - 1;

    loss_beat_t           want_q[$];
    longint unsigned      pow2_frac[17];
    longint               logits[NLOGIT];
    int unsigned          vocab;
    int unsigned          wr_ptr;
    longint               cur_max;
    longint unsigned      sum_exp;
    int unsigned          tgt_idx;
    int unsigned          rd_ptr;
    longint               total;
    int unsigned          nrows;
    int                   fails;

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // exp(d) in Q0.16 for d in Q.10, d clipped to <= 0
    function automatic longint unsigned exp_fix(longint d);
        longint unsigned mag, y, k, f, r;
        if (d > 0) d = 0;
        mag = -d;
        y   = (mag * 94548) >> 10;
        k   = y >> 16;
        f   = y & 64'hFFFF;
        r   = 64'd1 << 30;
        for (int j = 1; j <= 16; j++)
            if ((f >> (16 - j)) & 1) r = (r * pow2_frac[j]) >> 30;
        if (14 + k >= 63) return 0;
        return r >> (14 + k);
    endfunction

    // ln(sum / 65536) in Q.16
    function automatic longint ln_fix(longint unsigned sum);
        int              k;
        longint unsigned m, frac, l2;
        k    = 31;
        frac = 0;
        while (k > 0 && !sum[k]) k--;
        m = (k <= 30) ? (sum << (30 - k)) : (sum >> (k - 30));
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m    = m >> 1;
            end
        end
        l2 = (longint'(k) << 16) + frac;
        return longint'((l2 * 45426) >> 16) - 726816;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic int unsigned vocab_eff();
        if (vocab == 0) return 1;
        if (vocab > NLOGIT) return NLOGIT;
        return vocab;
    endfunction

    initial begin
        pow2_frac[0] = 64'd1 << 29;
        for (int j = 1; j <= 16; j++) pow2_frac[j] = root64(pow2_frac[j-1] << 30);
    end

    // apply one input beat, queue the result it causes
    task automatic take_beat(t_op op, logic [15:0] lg, logic [15:0] tg);
        int unsigned     v;
        longint          t, ce;
        longint unsigned e, p, s;
        loss_beat_t      b;
        v = vocab_eff();
        case (op)
            OP_LOAD: begin
                if (wr_ptr < v) begin
                    logits[wr_ptr] = longint'($signed(lg));
                    if (wr_ptr == 0 || logits[wr_ptr] > cur_max) cur_max = logits[wr_ptr];
                    wr_ptr++;
                end
            end
            OP_CLOSE: begin
                s = 0;
                for (int i = 0; i < v; i++) begin
                    s = s + exp_fix(logits[i] - cur_max);
                    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
                end
                if (s == 0) s = 1;
                sum_exp = s;
                t = longint'($signed(tg));
                if (t < 0) t = 0;
                if (t >= v) t = v - 1;
                tgt_idx = t;
                ce = clip32((cur_max - logits[tgt_idx]) * 64 + ln_fix(sum_exp));
                total = total + ce;
                if (total > TOT_MAX) total = TOT_MAX;
                if (total < TOT_MIN) total = TOT_MIN;
                if (nrows < 65535) nrows++;
                wr_ptr  = 0;
                rd_ptr  = 0;
                b.kind  = KIND_ROW;
                b.value = ce[31:0];
                b.last  = 1'b0;
                want_q.push_back(b);
            end
            OP_GRAD: begin
                if (rd_ptr < v) begin
                    e = exp_fix(logits[rd_ptr] - cur_max);
                    s = (sum_exp != 0) ? sum_exp : 1;
                    p = (e * 65536) / s;
                    if (p > 65536) p = 65536;
                    t = longint'(p) - ((rd_ptr == tgt_idx) ? 65536 : 0);
                    b.kind  = KIND_GRAD;
                    b.value = t[31:0];
                    b.last  = (rd_ptr == v - 1);
                    want_q.push_back(b);
                    rd_ptr++;
                end
            end
            default: begin
                t = 0;
                if (nrows != 0) t = clip32(total / longint'(nrows));
                total   = 0;
                nrows   = 0;
                b.kind  = KIND_MEAN;
                b.value = t[31:0];
                b.last  = 1'b0;
                want_q.push_back(b);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        loss_beat_t b;
        if (!i_rst_n) begin
            want_q.delete();
            wr_ptr  = 0;
            cur_max = -32768;
            sum_exp = 0;
            tgt_idx = 0;
            rd_ptr  = 0;
            total   = 0;
            nrows   = 0;
            vocab   = VOCAB_RST;
            fails   = 0;
        end else begin
            if (i_cfg_we) vocab = i_cfg_data;
            if (i_in.valid && i_in.ready) take_beat(i_in.op, i_in.logit, i_in.target);
            // compare each returned beat with the oldest prediction
            if (i_out.valid && i_out.ready) begin
                if (want_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected beat kind=%0d value=%0d", i_out.kind,
                                 $signed(i_out.value));
                end else begin
                    b = want_q.pop_front();
                    if (b.kind !== i_out.kind || b.value !== i_out.value ||
                        b.last !== i_out.last_of_row) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp kind=%0d value=%0d last=%0d, got kind=%0d value=%0d last=%0d",
                                     b.kind, $signed(b.value), b.last, i_out.kind,
                                     $signed(i_out.value), i_out.last_of_row);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= want_q.size();
    end
endmodule

// ===== test/softmax_cross_entropy_grad_tb.sv =====
module softmax_cross_entropy_grad_tb;
    import sceg_pkg::*;

    localparam int LIMIT = 3000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_data;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    bit                 calm;
    bit                 hold_req;
    int unsigned        vocab_now;
    int unsigned        load_ptr;
    int unsigned        filled;
    int                 beats_sent;
    logic [15:0]        prev_logit;

    sceg_in_if  in_ch ();
    sceg_out_if out_ch ();

    softmax_cross_entropy_grad dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    sceg_scoreboard sb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL softmax_cross_entropy_grad");
            $finish;
        end
    end

    // result sink: random stall bursts, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                out_ch.ready <= 1'b1;
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int unsigned eff(int unsigned c);
        if (c == 0) return 1;
        if (c > 4096) return 4096;
        return c;
    endfunction

    task automatic send_beat(t_op op, logic [15:0] lg, logic [15:0] tg);
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.logit  <= lg;
        in_ch.target <= tg;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // track the store fill and the count of beats sent
        if (op == OP_LOAD) begin
            if (load_ptr < vocab_now) begin
                load_ptr++;
                if (load_ptr > filled) filled = load_ptr;
                beats_sent++;
            end
        end else begin
            if (op == OP_CLOSE) load_ptr = 0;
            beats_sent++;
        end
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_vocab(int unsigned c);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        vocab_now = eff(c);
    endtask

    function automatic logic [15:0] rand_logit();
        logic [15:0] x;
        case ($urandom_range(0, 3))
            0: x = $urandom;
            1: x = 16'($urandom_range(0, 4095) - 2048);
            2: x = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: x = prev_logit + 16'($urandom_range(0, 1023) - 512);
        endcase
        prev_logit = x;
        return x;
    endfunction

    function automatic logic [15:0] rand_target();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 16'($urandom_range(0, vocab_now - 1));
    endfunction

    // one row: loads, close, gradient reads
    task automatic do_row(int nload, int ngrad);
        for (int i = 0; i < nload; i++) send_beat(OP_LOAD, rand_logit(), 16'h0);
        send_beat(OP_CLOSE, 16'h0, rand_target());
        for (int i = 0; i < ngrad; i++) send_beat(OP_GRAD, 16'h0, 16'h0);
    endtask

    task automatic run_phase(int unsigned c, int budget);
        int start;
        int nl;
        set_vocab(c);
        start = beats_sent;
        // first row is always full so every entry in use is written
        do_row(vocab_now, vocab_now);
        while (beats_sent - start < budget) begin
            case ($urandom_range(0, 5))
                0: nl = $urandom_range(0, vocab_now);
                1: nl = vocab_now + $urandom_range(1, 3);
                default: nl = vocab_now;
            endcase
            if (c == 16 && !hold_req && beats_sent - start > 20) hold_req = 1'b1;
            do_row(nl, $urandom_range(0, 2) == 0 ? $urandom_range(0, vocab_now + 2)
                                                 : vocab_now);
            if ($urandom_range(0, 4) == 0) send_beat(OP_SEQ, $urandom, $urandom);
        end
        send_beat(OP_SEQ, 16'h0, 16'h0);
        in_ch.valid <= 1'b0;
        wait_idle();
    endtask

    initial begin
        in_ch.valid  <= 1'b0;
        in_ch.op     <= OP_LOAD;
        in_ch.logit  <= '0;
        in_ch.target <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        vocab_now  = 4096;
        load_ptr   = 0;
        filled     = 0;
        beats_sent = 0;
        prev_logit = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-logit rows, empty sequence, reads before any close
        set_vocab(1);
        send_beat(OP_SEQ, 16'h0, 16'h0);
        send_beat(OP_LOAD, 16'h8000, 16'h0);
        send_beat(OP_GRAD, 16'h0, 16'h0);
        send_beat(OP_CLOSE, 16'h0, 16'h8000);
        send_beat(OP_LOAD, 16'h7FFF, 16'h0);
        send_beat(OP_GRAD, 16'h0, 16'h0);
        send_beat(OP_GRAD, 16'h0, 16'h0);
        send_beat(OP_CLOSE, 16'h0, 16'h7FFF);
        send_beat(OP_SEQ, 16'h0, 16'h0);
        in_ch.valid <= 1'b0;
        wait_idle();
        // directed: extreme logits, target past the end, reads after new loads
        set_vocab(3);
        send_beat(OP_LOAD, 16'h7FFF, 16'h0);
        send_beat(OP_LOAD, 16'h8000, 16'h0);
        send_beat(OP_LOAD, 16'h0000, 16'h0);
        send_beat(OP_CLOSE, 16'h0, 16'h7FFF);
        send_beat(OP_GRAD, 16'h0, 16'h0);
        send_beat(OP_LOAD, 16'hFFFF, 16'h0);
        send_beat(OP_GRAD, 16'h0, 16'h0);
        send_beat(OP_GRAD, 16'h0, 16'h0);
        send_beat(OP_GRAD, 16'h0, 16'h0);
        send_beat(OP_CLOSE, 16'h0, 16'h0001);
        send_beat(OP_SEQ, 16'h0, 16'h0);
        in_ch.valid <= 1'b0;
        wait_idle();

        // random phases over several vocabulary sizes
        run_phase(0, 60);
        run_phase(2, 110);
        run_phase(5, 130);
        run_phase(16, 170);
        run_phase(8, 130);
        run_phase(3, 110);
        run_phase(11, 120);
        calm = 1'b1;
        run_phase(4, 80);

        if (fail_count == 0) begin
            $display("PASS softmax_cross_entropy_grad");
        end else begin
            $display("FAIL softmax_cross_entropy_grad");
        end
        $finish;
    end
endmodule
